/* sv/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion lbl failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion lbl failed");

`endif

/* sv/vtgd_pkg.sv */
// types and constants of the vector tile geometry decoder
package vtgd_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int WORD_WIDTH      = 32;
    localparam int CMD_ID_BITS     = 3;
    localparam int PARAMS_WIDTH    = 30;

    localparam logic [CMD_ID_BITS-1:0] ID_MOVETO    = 3'd1;
    localparam logic [CMD_ID_BITS-1:0] ID_LINETO    = 3'd2;
    localparam logic [CMD_ID_BITS-1:0] ID_CLOSEPATH = 3'd7;

    // result kinds
    typedef enum logic [1:0] {
        KIND_POINT     = 2'd0,
        KIND_DONE      = 2'd1,
        KIND_TRUNCATED = 2'd2
    } kind_t;

    // one result item
    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               new_polygon;
        logic               closes_polygon;
        logic               last;
    } result_t;

endpackage

/* sv/vector_tile_geometry_decoder_core.sv */
// vector tile geometry decoder: command stream to points and feature markers
//
// One geometry word is taken per cycle while in_ready is high. Each word gives
// zero, one or two results (a point and/or an end-of-feature marker); these
// sit in a two-entry result register and leave one per cycle while out_ready
// is high, so a word that gives two results holds off the next word until the
// first has left. The cursor add and the decode sit between the input handshake
// and the result register; the rate is set by the one result per cycle output.
// Cursors wrap at COORD_WIDTH bits and are sign-extended to 32 bits.
module vector_tile_geometry_decoder_core #(
    parameter int COORD_WIDTH = vtgd_pkg::COORD_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [vtgd_pkg::WORD_WIDTH-1:0]    word,
    input  logic signed [31:0]                 elevation,
    input  logic                               feature_end,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         kind,
    output logic signed [31:0]                 x,
    output logic signed [31:0]                 y,
    output logic signed [31:0]                 z,
    output logic                               new_polygon,
    output logic                               closes_polygon,
    output logic                               last
);

    localparam int PW     = vtgd_pkg::PARAMS_WIDTH;
    localparam int CB     = vtgd_pkg::CMD_ID_BITS;
    localparam int WORD_W = vtgd_pkg::WORD_WIDTH;

    // decoder state
    logic                   expect_params_reg, expect_params_next;
    logic [PW-1:0]          params_left_reg, params_left_next;
    logic                   is_moveto_reg, is_moveto_next;
    logic [COORD_WIDTH-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_WIDTH-1:0] cursor_y_reg, cursor_y_next;
    logic [COORD_WIDTH-1:0] start_x_reg, start_x_next;
    logic [COORD_WIDTH-1:0] start_y_reg, start_y_next;
    logic                   polygon_open_reg, polygon_open_next;

    // result buffer
    vtgd_pkg::result_t res0_reg, res0_next, res1_reg, res1_next;
    logic [1:0]        cnt_reg, cnt_next;

    logic                     in_fire, out_fire;
    logic [31:0]              zz;
    logic [COORD_WIDTH-1:0]   delta;
    logic [CB-1:0]            cmd_id;
    logic                     pt_valid;
    vtgd_pkg::result_t        pt, mk;
    logic [1:0]               n_res;
    vtgd_pkg::result_t        new0, new1;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);

    // zigzag decode of a parameter word
    assign zz     = (word >> 1) ^ {32{word[0]}};
    assign delta  = zz[COORD_WIDTH-1:0];
    assign cmd_id = word[CB-1:0];

    // state update and point generation for one word
    always_comb
    begin
        expect_params_next = expect_params_reg;
        params_left_next   = params_left_reg;
        is_moveto_next     = is_moveto_reg;
        cursor_x_next      = cursor_x_reg;
        cursor_y_next      = cursor_y_reg;
        start_x_next       = start_x_reg;
        start_y_next       = start_y_reg;
        polygon_open_next  = polygon_open_reg;
        pt_valid           = 1'b0;
        pt                 = '0;
        pt.kind            = vtgd_pkg::KIND_POINT;
        pt.z               = elevation;
        if (expect_params_reg)
        begin
            if (!params_left_reg[0])
            begin
                cursor_x_next = cursor_x_reg + delta;
            end
            else
            begin
                cursor_y_next = cursor_y_reg + delta;
                if (is_moveto_reg)
                begin
                    start_x_next = cursor_x_reg;
                    start_y_next = cursor_y_next;
                end
                pt_valid          = 1'b1;
                pt.x              = 32'(signed'(cursor_x_reg));
                pt.y              = 32'(signed'(cursor_y_next));
                pt.new_polygon    = is_moveto_reg || !polygon_open_reg;
                polygon_open_next = 1'b1;
            end
            params_left_next = params_left_reg - PW'(1);
            if (params_left_next == '0)
            begin
                expect_params_next = 1'b0;
            end
        end
        else
        begin
            if ((cmd_id == vtgd_pkg::ID_MOVETO) || (cmd_id == vtgd_pkg::ID_LINETO))
            begin
                is_moveto_next     = (cmd_id == vtgd_pkg::ID_MOVETO);
                params_left_next   = {word[WORD_W-1:CB], 1'b0};
                expect_params_next = (params_left_next != '0);
            end
            else if (cmd_id == vtgd_pkg::ID_CLOSEPATH)
            begin
                pt_valid          = 1'b1;
                pt.x              = 32'(signed'(start_x_reg));
                pt.y              = 32'(signed'(start_y_reg));
                pt.new_polygon    = !polygon_open_reg;
                pt.closes_polygon = 1'b1;
                polygon_open_next = 1'b0;
            end
        end

        // end-of-feature marker
        mk      = '0;
        mk.kind = expect_params_next ? vtgd_pkg::KIND_TRUNCATED : vtgd_pkg::KIND_DONE;
        mk.last = 1'b1;
        if (feature_end)
        begin
            expect_params_next = 1'b0;
            params_left_next   = '0;
            is_moveto_next     = 1'b0;
            cursor_x_next      = '0;
            cursor_y_next      = '0;
            start_x_next       = '0;
            start_y_next       = '0;
            polygon_open_next  = 1'b0;
        end
        pt.last = !feature_end;
    end

    // pack the results of this word
    always_comb
    begin
        new0  = pt;
        new1  = mk;
        n_res = 2'd0;
        if (pt_valid && feature_end)
        begin
            n_res = 2'd2;
        end
        else if (pt_valid)
        begin
            n_res = 2'd1;
        end
        else if (feature_end)
        begin
            n_res = 2'd1;
            new0  = mk;
        end
    end

    // result buffer control
    always_comb
    begin
        res0_next = res0_reg;
        res1_next = res1_reg;
        cnt_next  = cnt_reg;
        if (in_fire)
        begin
            res0_next = new0;
            res1_next = new1;
            cnt_next  = n_res;
        end
        else if (out_fire)
        begin
            res0_next = res1_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_params_reg <= 1'b0;
            params_left_reg   <= '0;
            is_moveto_reg     <= 1'b0;
            cursor_x_reg      <= '0;
            cursor_y_reg      <= '0;
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            polygon_open_reg  <= 1'b0;
            cnt_reg           <= 2'd0;
        end
        else
        begin
            if (in_fire)
            begin
                expect_params_reg <= expect_params_next;
                params_left_reg   <= params_left_next;
                is_moveto_reg     <= is_moveto_next;
                cursor_x_reg      <= cursor_x_next;
                cursor_y_reg      <= cursor_y_next;
                start_x_reg       <= start_x_next;
                start_y_reg       <= start_y_next;
                polygon_open_reg  <= polygon_open_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res0_reg <= res0_next;
        res1_reg <= res1_next;
    end

    assign out_valid      = (cnt_reg != 2'd0);
    assign kind           = res0_reg.kind;
    assign x              = res0_reg.x;
    assign y              = res0_reg.y;
    assign z              = res0_reg.z;
    assign new_polygon    = res0_reg.new_polygon;
    assign closes_polygon = res0_reg.closes_polygon;
    assign last           = res0_reg.last;

endmodule

/* sv/vtgd_checker.sv */
// port-level checks of the geometry decoder, bound to the decoder core module
`include "assert_macros.svh"

module vtgd_port_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         kind,
    input logic signed [31:0] x,
    input logic signed [31:0] y,
    input logic signed [31:0] z,
    input logic               new_polygon,
    input logic               closes_polygon,
    input logic               last
);

    // no unused kind code ever leaves the block
    `ASSERT_NEVER(a_kind_code, clk, rst_n, out_valid && (kind > vtgd_pkg::KIND_TRUNCATED))

    // markers carry zero payload and end the request's results
    `ASSERT_CLK(a_marker_zero, clk, rst_n,
        (out_valid && (kind != vtgd_pkg::KIND_POINT)) |->
        (last && (x == 32'sd0) && (y == 32'sd0) && (z == 32'sd0)
         && !new_polygon && !closes_polygon))

    // a result that is not the last one is followed by another
    `ASSERT_CLK(a_more_follows, clk, rst_n, (out_valid && out_ready && !last) |=> out_valid)

    // a stalled result holds its payload
    `ASSERT_CLK(a_out_hold, clk, rst_n,
        (out_valid && !out_ready) |=>
        (out_valid && $stable(kind) && $stable(x) && $stable(y) && $stable(last)))

endmodule

bind vector_tile_geometry_decoder_core vtgd_port_checker u_vtgd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .x              (x),
    .y              (y),
    .z              (z),
    .new_polygon    (new_polygon),
    .closes_polygon (closes_polygon),
    .last           (last)
);
